// ----- sv/sitra_pkg.sv -----
// sitra_pkg: shared types, constants and helpers for the radix ASCII converter.
// No dependencies.
package sitra_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned DigitWidth = 6;
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned MaxDigits  = 32;
   localparam int unsigned StackAddrWidth = $clog2(MaxDigits);
   localparam int unsigned CountWidth = $clog2(MaxDigits + 1);
   localparam int unsigned BitsPerStep = 8;
   localparam int unsigned StepsPerDigit = ValueWidth / BitsPerStep;
   localparam int unsigned StepCountWidth = $clog2(StepsPerDigit);

   localparam logic [DigitWidth-1:0] RadixMin   = 6'd2;
   localparam logic [DigitWidth-1:0] RadixMax   = 6'd36;
   localparam logic [DigitWidth-1:0] RadixReset = 6'd10;

   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharA     = 8'h41;
   localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic [0:0] RegRadix = 1'b0;

   typedef struct packed {
      logic load;
      logic div;
      logic push;
      logic emit_sign;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic sp_one;
      logic neg;
      logic out_free;
   } status_type;

   function automatic logic [DigitWidth-1:0] radix_clamp(input logic [DigitWidth-1:0] r);
      logic [DigitWidth-1:0] res;
      res = r;
      if (r < RadixMin) res = RadixMin;
      if (r > RadixMax) res = RadixMax;
      return res;
   endfunction

   function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
      logic [CharWidth-1:0] res;
      if (d < 6'd10) res = CharZero + {2'b00, d};
      else res = CharA + {2'b00, d} - 8'd10;
      return res;
   endfunction

endpackage

// ----- sv/sitra_ctrl.sv -----
// sitra_ctrl: sequencer for load, digit division, sign and character output.
// Depends on sitra_pkg.
module sitra_ctrl
   import sitra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_SIGN,
      S_POP
   } state_type;

   state_type state_ff, state_in;
   logic [StepCountWidth-1:0] step_ff, step_in;
   logic last_step;

   assign last_step = (step_ff == StepCountWidth'(StepsPerDigit - 1));
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            step_in  = step_ff + 1'b1;
            if (last_step) begin
               cmd.push = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.quot_zero) state_in = S_DIV;
            else if (status.neg) state_in = S_SIGN;
            else state_in = S_POP;
         end
         S_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (status.out_free) begin
               cmd.pop = 1'b1;
               if (status.sp_one) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- sv/sitra_dp.sv -----
// sitra_dp: magnitude divider (8 quotient bits per cycle), digit stack, output word.
// Depends on sitra_pkg.
module sitra_dp
   import sitra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic signed [31:0]    req_value,
   input  logic [DigitWidth-1:0] radix,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CharWidth-1:0]  rsp_character,
   output logic                  rsp_last
);

   logic [ValueWidth-1:0] work_ff, work_in;
   logic [DigitWidth-1:0] rem_ff, rem_in;
   logic [DigitWidth-1:0] base_ff;
   logic                  neg_ff;
   logic [CountWidth-1:0] sp_ff, sp_in;
   logic [DigitWidth-1:0] stk_ff [MaxDigits];
   logic                  out_valid_ff, out_valid_in;
   logic [CharWidth-1:0]  char_ff;
   logic                  last_ff;
   logic [ValueWidth-1:0] div_w;
   logic [DigitWidth-1:0] div_r;
   logic [CountWidth-1:0] sp_dec;

   always_comb begin
      logic [DigitWidth:0] t;
      logic [DigitWidth-1:0] r;
      logic [ValueWidth-1:0] w;
      r = rem_ff;
      w = work_ff;
      for (int i = 0; i < BitsPerStep; i++) begin
         t = {r, w[ValueWidth-1]};
         w = {w[ValueWidth-2:0], 1'b0};
         if (t >= {1'b0, base_ff}) begin
            t = t - {1'b0, base_ff};
            w[0] = 1'b1;
         end
         r = t[DigitWidth-1:0];
      end
      div_w = w;
      div_r = r;
   end

   assign sp_dec = sp_ff - 1'b1;

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      sp_in   = sp_ff;
      if (cmd.load) begin
         work_in = req_value[ValueWidth-1] ? (ValueWidth'(0) - ValueWidth'(req_value))
                                           : ValueWidth'(req_value);
         rem_in  = '0;
         sp_in   = '0;
      end else if (cmd.div) begin
         work_in = div_w;
         rem_in  = cmd.push ? '0 : div_r;
         if (cmd.push) sp_in = sp_ff + 1'b1;
      end else if (cmd.pop) begin
         sp_in = sp_dec;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & rsp_stall;
      if (cmd.emit_sign || cmd.pop) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (cmd.load) begin
         base_ff <= radix_clamp(radix);
         neg_ff  <= req_value[ValueWidth-1];
      end
      if (cmd.push) stk_ff[sp_ff[StackAddrWidth-1:0]] <= div_r;
      if (cmd.emit_sign) begin
         char_ff <= CharMinus;
         last_ff <= 1'b0;
      end else if (cmd.pop) begin
         char_ff <= digit_char(stk_ff[sp_dec[StackAddrWidth-1:0]]);
         last_ff <= (sp_ff == CountWidth'(1));
      end
   end

   assign status.quot_zero = (work_ff == '0);
   assign status.sp_one    = (sp_ff == CountWidth'(1));
   assign status.neg       = neg_ff;
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid     = out_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CountWidth'(MaxDigits))
      else $error("digit stack overflow");

   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (rem_ff == '0) && (sp_ff == '0))
      else $error("load did not clear divider state");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (sp_ff != '0))
      else $error("pop from empty digit stack");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.emit_sign) |=> out_valid_ff)
      else $error("emitted word not presented");

endmodule

// ----- sv/signed_int_to_radix_ascii.sv -----
// Converts a signed 32-bit integer to ASCII text in a base of 2 to 36, most
// significant character first, one character per output word, '-' leading for
// negative values, last flag on the final character. Digits come from a shared
// long divider that retires 8 quotient bits per cycle; each digit is a run of
// divide steps followed by a zero check, and the stacked digits are then
// popped out after the sign, if any. Only once the last digit is popped is the
// next word accepted. radix is read at acceptance; values 0-1 act as 2 and
// 37-63 as 36. Depends on sitra_pkg, sitra_ctrl and sitra_dp.
module signed_int_to_radix_ascii
   import sitra_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_character,
   output logic                    rsp_last,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   logic [DigitWidth-1:0] radix_ff, radix_in;
   cmd_type    cmd;
   status_type status;
   logic       csr_wr;
   logic       csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CsrAddrWidth-1] == RegRadix);
   assign csr_wr  = psel & penable & pwrite & pready & csr_hit;
   assign radix_in = csr_wr ? pwdata[DigitWidth-1:0] : radix_ff;
   assign prdata  = csr_hit ? {{(CsrDataWidth-DigitWidth){1'b0}}, radix_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RadixReset;
      end else begin
         radix_ff <= radix_in;
      end
   end

   sitra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sitra_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .radix         (radix_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- test/signed_int_to_radix_ascii_test.sv -----
// Self-checking test of signed_int_to_radix_ascii: signed words go in, and every
// ASCII character that comes out is checked against a local digit predictor.
// Depends on sitra_pkg and the RTL of the block.
module signed_int_to_radix_ascii_test;
   import sitra_pkg::*;

   localparam int IdleLimit    = 5000;
   localparam int SettleCycles = 20;
   localparam int HoldAt       = 45;
   localparam int HoldCycles   = 400;
   localparam logic [CsrAddrWidth-1:0] RadixAddr = {RegRadix, 2'b00};

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } glyph_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [31:0]      req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [7:0]              rsp_character;
   logic                    rsp_last;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   logic signed [31:0] value_q[$];
   glyph_type          expected_glyphs[$];
   logic [5:0]         radix_setting = RadixReset;
   int                 errors = 0;
   int                 values_taken = 0;
   bit                 calm = 1'b0;
   int                 gap_left = 0;
   int                 stall_left = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   int                 quiet_cycles = 0;
   logic [31:0]        corner_values [5];
   logic [5:0]         corner_radix [5];
   logic [5:0]         sweep_radix [8];

   signed_int_to_radix_ascii u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void spell_value(input logic [31:0] raw);
      logic [31:0]  mag;
      int unsigned  base;
      int unsigned  d;
      logic [7:0]   digits[$];
      mag = raw[31] ? 32'd0 - raw : raw;
      if (radix_setting < RadixMin) base = RadixMin;
      else if (radix_setting > RadixMax) base = RadixMax;
      else base = radix_setting;
      do begin
         d = mag % base;
         digits.push_front(d < 10 ? CharZero + 8'(d) : CharA + 8'(d - 10));
         mag = mag / base;
      end while (mag != 0);
      if (raw[31]) expected_glyphs.push_back('{CharMinus, 1'b0});
      foreach (digits[i]) expected_glyphs.push_back('{digits[i], i == digits.size() - 1});
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            spell_value(req_value);
            values_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (value_q.size() > 0) begin
               req_valid <= 1'b1;
               req_value <= value_q.pop_front();
               if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      glyph_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_glyphs.size() == 0) begin
               if (errors < 10)
                  $display("unexpected word: char %h last %b", rsp_character, rsp_last);
               errors++;
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_character !== want.ch || rsp_last !== want.last) begin
                  if (errors < 10)
                     $display("mismatch: expected char %h last %b, got char %h last %b",
                              want.ch, want.last, rsp_character, rsp_last);
                  errors++;
               end
            end
         end
         // one long hold-off so the input side backs up
         if (!hold_done && values_taken >= HoldAt) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IdleLimit) begin
            $display("timeout: no traffic for %0d cycles", quiet_cycles);
            $display("[signed_int_to_radix_ascii] ERROR");
            $finish;
         end
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (value_q.size() != 0 || req_valid || expected_glyphs.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_radix(input logic [5:0] r);
      logic [31:0] word;
      word = $urandom;
      word[5:0] = r;
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= RadixAddr;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      radix_setting = r;
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[5:0] !== r) begin
         if (errors < 10) $display("radix readback: expected %0d, got %0d", r, prdata[5:0]);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic queue_random_values(input int n);
      logic [31:0] v;
      repeat (n) begin
         case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 200);
            3: v = 32'h8000_0000 + $urandom_range(0, 3);
            4: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: v = $urandom >> $urandom_range(0, 31);
         endcase
         if ($urandom_range(0, 2) == 0) v = 32'd0 - v;
         value_q.push_back(v);
      end
   endtask

   initial begin
      corner_values = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd35};
      corner_radix  = '{RadixReset, 6'd2, 6'd36, 6'd0, 6'd63};
      sweep_radix   = '{6'd16, 6'd1, 6'd37, 6'd3, 6'd7, 6'd36,
                        6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_radix[i]) begin
         drain();
         if (i > 0) write_radix(corner_radix[i]);
         foreach (corner_values[j]) value_q.push_back(corner_values[j]);
      end

      foreach (sweep_radix[i]) begin
         drain();
         write_radix(sweep_radix[i]);
         if (i == 7) calm = 1'b1;
         queue_random_values(i == 0 ? 60 : 30);
      end

      drain();
      if (errors == 0) begin
         $display("[signed_int_to_radix_ascii] OK");
      end else begin
         $display("[signed_int_to_radix_ascii] ERROR");
      end
      $finish;
   end

endmodule
